>>> hdl/qp2v_pkg.sv
// Shared types and constants for the quaternion pose to view matrix block.
`default_nettype none

package qp2v_pkg;

   // Quaternion component after optional negation (covers +32768)
   localparam int QW    = 17;
   // Position component after optional negation (covers +2^31)
   localparam int PW    = 33;
   // Quaternion product, Q2.28, exact
   localparam int PRODW = 32;
   // Rotation entry before rounding, Q2.28 with headroom for doubling
   localparam int EW    = 36;
   // Rotation entry after rounding to Q8.16; the magnitude stays below 2^21
   localparam int MW    = EW - 12;
   // Rotation entry times position, Q25.32, exact
   localparam int PMW   = MW + PW;
   // Negated sum of three such products
   localparam int AW    = PMW + 3;
   // Output entry width
   localparam int FW    = 32;

   localparam logic signed [EW-1:0] ONE_Q28  = EW'(64'sd268435456);
   localparam logic signed [FW-1:0] ONE_Q16  = 32'sh0001_0000;

   // Row codes
   localparam logic [1:0] ROW_FIRST = 2'd0;
   localparam logic [1:0] ROW_LAST  = 2'd3;

   typedef logic signed [MW-1:0] ment_type;
   typedef logic signed [PW-1:0] pos_type;
   typedef logic signed [FW-1:0] fix_type;
   typedef ment_type [2:0][2:0]  mat3_type;

   // One input item: a pose
   typedef struct packed {
      logic signed [15:0] quat_x;
      logic signed [15:0] quat_y;
      logic signed [15:0] quat_z;
      logic signed [15:0] quat_w;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
   } req_type;

   // One result item: a matrix row
   typedef struct packed {
      logic [1:0]         row_index;
      logic signed [31:0] col0;
      logic signed [31:0] col1;
      logic signed [31:0] col2;
      logic signed [31:0] col3;
      logic               last_row;
   } rsp_type;

   // Rotation entries plus the (possibly flipped) position
   typedef struct packed {
      mat3_type      m;
      pos_type [2:0] p;
   } rot_type;

   // Full view matrix: rotation rows and the translation row
   typedef struct packed {
      mat3_type      m;
      fix_type [2:0] t;
   } mat_type;

endpackage

`default_nettype wire

>>> hdl/qp2v_rot.sv
// Rotation pipeline: handedness flip, quaternion products, rounded matrix entries.
`default_nettype none

module qp2v_rot
   import qp2v_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    left_handed,
   input  wire logic    in_valid,
   output logic         in_ready,
   input  wire req_type in_data,
   output logic         out_valid,
   input  wire logic    out_ready,
   output rot_type      out_data
);

   // Sign-extend a product to entry width
   function automatic logic signed [EW-1:0] ext(input logic signed [PRODW-1:0] v);
      return {{(EW-PRODW){v[PRODW-1]}}, v};
   endfunction

   // Drop 12 bits, rounding half toward plus infinity
   function automatic ment_type to_q16(input logic signed [EW-1:0] e);
      logic signed [EW-1:0] t;
      t = e + EW'(64'sd2048);
      return t[EW-1:12];
   endfunction

   // Stage 1: flipped inputs
   logic               v1_ff;
   logic signed [QW-1:0] qx_ff, qy_ff, qz_ff, qw_ff;
   logic signed [QW-1:0] qx_in, qy_in, qz_in, qw_in;
   pos_type [2:0]        p1_ff, p1_in;

   // Stage 2: products
   logic               v2_ff;
   logic signed [PRODW-1:0] xx_ff, yy_ff, zz_ff, xy_ff, xz_ff, yz_ff, wx_ff, wy_ff, wz_ff;
   pos_type [2:0]        p2_ff;

   // Stage 3: rounded entries
   logic               v3_ff;
   mat3_type           m3_ff, m3_in;
   pos_type [2:0]      p3_ff;

   logic rdy1, rdy2, rdy3;

   assign rdy3     = !v3_ff || out_ready;
   assign rdy2     = !v2_ff || rdy3;
   assign rdy1     = !v1_ff || rdy2;
   assign in_ready = rdy1;

   // Negate pos z and quat x, y for left-handed frames, at one extra bit
   always_comb begin
      qx_in = {in_data.quat_x[15], in_data.quat_x};
      qy_in = {in_data.quat_y[15], in_data.quat_y};
      qz_in = {in_data.quat_z[15], in_data.quat_z};
      qw_in = {in_data.quat_w[15], in_data.quat_w};
      p1_in[0] = {in_data.pos_x[31], in_data.pos_x};
      p1_in[1] = {in_data.pos_y[31], in_data.pos_y};
      p1_in[2] = {in_data.pos_z[31], in_data.pos_z};
      if (left_handed) begin
         qx_in    = -qx_in;
         qy_in    = -qy_in;
         p1_in[2] = -p1_in[2];
      end
   end

   // Build the nine rotation entries in Q2.28 and round to Q8.16
   always_comb begin
      m3_in[0][0] = to_q16(ONE_Q28 - ((ext(yy_ff) + ext(zz_ff)) <<< 1));
      m3_in[0][1] = to_q16((ext(xy_ff) - ext(wz_ff)) <<< 1);
      m3_in[0][2] = to_q16((ext(xz_ff) + ext(wy_ff)) <<< 1);
      m3_in[1][0] = to_q16((ext(xy_ff) + ext(wz_ff)) <<< 1);
      m3_in[1][1] = to_q16(ONE_Q28 - ((ext(xx_ff) + ext(zz_ff)) <<< 1));
      m3_in[1][2] = to_q16((ext(yz_ff) - ext(wx_ff)) <<< 1);
      m3_in[2][0] = to_q16((ext(xz_ff) - ext(wy_ff)) <<< 1);
      m3_in[2][1] = to_q16((ext(yz_ff) + ext(wx_ff)) <<< 1);
      m3_in[2][2] = to_q16(ONE_Q28 - ((ext(xx_ff) + ext(yy_ff)) <<< 1));
   end

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= in_valid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
      end
   end

   // Advance payload
   always_ff @(posedge clock) begin
      if (rdy1 && in_valid) begin
         qx_ff <= qx_in;
         qy_ff <= qy_in;
         qz_ff <= qz_in;
         qw_ff <= qw_in;
         p1_ff <= p1_in;
      end
      if (rdy2 && v1_ff) begin
         xx_ff <= PRODW'(qx_ff) * PRODW'(qx_ff);
         yy_ff <= PRODW'(qy_ff) * PRODW'(qy_ff);
         zz_ff <= PRODW'(qz_ff) * PRODW'(qz_ff);
         xy_ff <= PRODW'(qx_ff) * PRODW'(qy_ff);
         xz_ff <= PRODW'(qx_ff) * PRODW'(qz_ff);
         yz_ff <= PRODW'(qy_ff) * PRODW'(qz_ff);
         wx_ff <= PRODW'(qw_ff) * PRODW'(qx_ff);
         wy_ff <= PRODW'(qw_ff) * PRODW'(qy_ff);
         wz_ff <= PRODW'(qw_ff) * PRODW'(qz_ff);
         p2_ff <= p1_ff;
      end
      if (rdy3 && v2_ff) begin
         m3_ff <= m3_in;
         p3_ff <= p2_ff;
      end
   end

   assign out_valid  = v3_ff;
   assign out_data.m = m3_ff;
   assign out_data.p = p3_ff;

endmodule

`default_nettype wire

>>> hdl/qp2v_trans.sv
// Translation pipeline: rotation entries times position, negated, rounded, saturated.
`default_nettype none

module qp2v_trans
   import qp2v_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    in_valid,
   output logic         in_ready,
   input  wire rot_type in_data,
   output logic         out_valid,
   input  wire logic    out_ready,
   output mat_type      out_data
);

   localparam int SW = AW - 16;
   localparam logic signed [SW-1:0] SAT_MAX = SW'(64'sd2147483647);
   localparam logic signed [SW-1:0] SAT_MIN = SW'(-64'sd2147483648);

   // Stage 4: nine products
   logic                  v4_ff;
   logic signed [PMW-1:0] pm_ff [3][3];
   logic signed [PMW-1:0] pm_in [3][3];
   mat3_type              m4_ff;

   // Stage 5: translation row
   logic                  v5_ff;
   fix_type [2:0]         t5_ff, t5_in;
   mat3_type              m5_ff;

   logic rdy4, rdy5;

   assign rdy5     = !v5_ff || out_ready;
   assign rdy4     = !v4_ff || rdy5;
   assign in_ready = rdy4;

   // Multiply each rotation entry by the position component of its row
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            pm_in[i][j] = PMW'($signed(in_data.m[i][j])) * PMW'($signed(in_data.p[i]));
         end
      end
   end

   // Sum each column, negate, round half up by 16 bits, saturate
   always_comb begin
      logic signed [AW-1:0] acc;
      logic signed [SW-1:0] sh;
      for (int j = 0; j < 3; j++) begin
         acc = AW'(64'sd32768)
               - AW'(pm_ff[0][j]) - AW'(pm_ff[1][j]) - AW'(pm_ff[2][j]);
         sh  = acc[AW-1:16];
         if (sh > SAT_MAX) begin
            t5_in[j] = SAT_MAX[FW-1:0];
         end else if (sh < SAT_MIN) begin
            t5_in[j] = SAT_MIN[FW-1:0];
         end else begin
            t5_in[j] = sh[FW-1:0];
         end
      end
   end

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         if (rdy4) v4_ff <= in_valid;
         if (rdy5) v5_ff <= v4_ff;
      end
   end

   // Advance payload
   always_ff @(posedge clock) begin
      if (rdy4 && in_valid) begin
         pm_ff <= pm_in;
         m4_ff <= in_data.m;
      end
      if (rdy5 && v4_ff) begin
         t5_ff <= t5_in;
         m5_ff <= m4_ff;
      end
   end

   assign out_valid  = v5_ff;
   assign out_data.m = m5_ff;
   assign out_data.t = t5_ff;

endmodule

`default_nettype wire

>>> hdl/qp2v_row_ser.sv
// Output register that holds one view matrix and emits it as four row items.
`default_nettype none

module qp2v_row_ser
   import qp2v_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    in_valid,
   output logic         in_ready,
   input  wire mat_type in_data,
   output logic         out_valid,
   input  wire logic    out_ready,
   output rsp_type      out_data
);

   logic       v_ff;
   logic [1:0] row_ff;
   mat_type    mat_ff;
   logic       last;
   logic       take;

   assign last     = (row_ff == ROW_LAST);
   assign in_ready = !v_ff || (out_ready && last);
   assign take     = in_valid && in_ready;

   // Load a new matrix, step the row on each delivered item
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff   <= 1'b0;
         row_ff <= ROW_FIRST;
      end else if (take) begin
         v_ff   <= 1'b1;
         row_ff <= ROW_FIRST;
      end else if (v_ff && out_ready) begin
         v_ff   <= !last;
         row_ff <= row_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (take) mat_ff <= in_data;
   end

   // Select the current row
   always_comb begin
      out_data.row_index = row_ff;
      out_data.last_row  = last;
      unique case (row_ff)
         ROW_LAST: begin
            out_data.col0 = mat_ff.t[0];
            out_data.col1 = mat_ff.t[1];
            out_data.col2 = mat_ff.t[2];
            out_data.col3 = ONE_Q16;
         end
         default: begin
            out_data.col0 = {{(FW-MW){mat_ff.m[row_ff][0][MW-1]}}, mat_ff.m[row_ff][0]};
            out_data.col1 = {{(FW-MW){mat_ff.m[row_ff][1][MW-1]}}, mat_ff.m[row_ff][1]};
            out_data.col2 = {{(FW-MW){mat_ff.m[row_ff][2][MW-1]}}, mat_ff.m[row_ff][2]};
            out_data.col3 = '0;
         end
      endcase
   end

   assign out_valid = v_ff;

endmodule

`default_nettype wire

>>> hdl/quaternion_pose_to_view_matrix.sv
// Top level: pose in, four view matrix rows out, with the handedness register.
//
// Each accepted pose yields four row items, rows 0 to 2 with the rounded rotation
// entries and row 3 with the negated, rounded and saturated translation. The pose
// rate is set by the single output channel, which delivers one row per cycle while
// rsp_ready is high and takes a new matrix only as the last row leaves; the five
// pipeline stages (flip, quaternion products, rotation rounding, position products,
// translation sum) take a pose every cycle unless back-pressure stalls them. Write
// csr_wdata (1 = left-handed: negate position z and quaternion x, y) only while idle.
`default_nettype none

module quaternion_pose_to_view_matrix
   import qp2v_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    csr_valid,
   output logic         csr_ready,
   input  wire logic    csr_wdata,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   logic    left_handed_ff;
   logic    rot_valid, rot_ready;
   rot_type rot_data;
   logic    mat_valid, mat_ready;
   mat_type mat_data;

   // Handedness register
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         left_handed_ff <= 1'b0;
      end else if (csr_valid) begin
         left_handed_ff <= csr_wdata;
      end
   end

   qp2v_rot u_rot (
      .clock       (clock),
      .reset       (reset),
      .left_handed (left_handed_ff),
      .in_valid    (req_valid),
      .in_ready    (req_ready),
      .in_data     (req_data),
      .out_valid   (rot_valid),
      .out_ready   (rot_ready),
      .out_data    (rot_data)
   );

   qp2v_trans u_trans (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (rot_valid),
      .in_ready  (rot_ready),
      .in_data   (rot_data),
      .out_valid (mat_valid),
      .out_ready (mat_ready),
      .out_data  (mat_data)
   );

   qp2v_row_ser u_row_ser (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mat_valid),
      .in_ready  (mat_ready),
      .in_data   (mat_data),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

   // Rows of one matrix follow in order
   a_row_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_data.last_row |=>
         rsp_valid && (rsp_data.row_index == 2'($past(rsp_data.row_index) + 2'd1)))
      else $error("row index did not advance");

   // A stalled row holds
   a_row_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled row changed");

   // Last row flag matches the row code, and column 3 is zero on rotation rows
   a_last_row: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.last_row == (rsp_data.row_index == ROW_LAST)) &&
                    (rsp_data.last_row || (rsp_data.col3 == '0)))
      else $error("row flag or column 3 wrong");

   // A new matrix enters the output register only after the last row leaves
   a_load: assert property (@(posedge clock) disable iff (reset)
      mat_valid && mat_ready && rsp_valid |-> rsp_data.last_row && rsp_ready)
      else $error("matrix overwritten");

endmodule

`default_nettype wire
